// File: hw/rtl/dnt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dnt_pkg
// Types and constants shared by the name text to wire format converter.
// ----------------------------------------------------------------------------
package dnt_pkg;

  localparam logic [7:0] DOT_CHAR  = 8'd46;
  localparam logic [8:0] CHARS_SAT = 9'h1FF;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_LABEL_LONG = 2'd2,
    ST_NAME_LONG  = 2'd3
  } status_e;

  typedef struct packed {
    logic       we;
    logic [7:0] addr;
    logic [7:0] wbyte;
    logic       done;
    status_e    status;
    logic [7:0] len;
  } res_t;

  typedef struct packed {
    res_t [2:0] slot;
    logic [1:0] cnt;
  } res_group_t;

endpackage

`default_nettype wire

// File: hw/rtl/dnt_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dnt_char_if / dnt_res_if
// Valid/ready channels for name characters and wire write results.
// ----------------------------------------------------------------------------
interface dnt_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface dnt_res_if;
  logic       valid;
  logic       ready;
  logic       write_enable;
  logic [7:0] wire_addr;
  logic [7:0] wire_byte;
  logic       done_res;
  logic [1:0] status;
  logic [7:0] wire_length;

  modport source (output valid, output write_enable, output wire_addr, output wire_byte,
                  output done_res, output status, output wire_length, input ready);
  modport sink   (input valid, input write_enable, input wire_addr, input wire_byte,
                  input done_res, input status, input wire_length, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dnt_parse.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dnt_parse
// Label state and per-character update; builds up to three results.
// ----------------------------------------------------------------------------
module dnt_parse #(
  parameter int MAX_LABEL = 63,
  parameter int MAX_NAME  = 255
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire logic [7:0]          ch_i,
  input  wire logic                last_i,
  output dnt_pkg::res_group_t      group_o
);
  import dnt_pkg::*;

  localparam logic [9:0] MaxLabel = 10'(MAX_LABEL);
  localparam logic [9:0] MaxName  = 10'(MAX_NAME);

  logic [7:0] ls_q, ls_d, ls_end;
  logic [6:0] lc_q, lc_d;
  logic [8:0] cs_q, cs_d;
  status_e    err_q, err_d;
  logic [8:0] addr;
  logic       root;
  logic       va, vb, vc;
  res_t       ra, rb, rc;

  assign root = last_i && (ch_i == DOT_CHAR) && (cs_q == 9'd0) && (err_q == ST_OK);
  assign addr = 9'(ls_q) + 9'd1 + 9'(lc_q);

  always_comb begin
    ra     = '0;
    rb     = '0;
    rc     = '0;
    va     = 1'b0;
    vb     = 1'b0;
    vc     = 1'b0;
    ls_d   = ls_q;
    lc_d   = lc_q;
    cs_d   = cs_q;
    err_d  = err_q;
    ls_end = '0;
    if (root) begin
      vc        = 1'b1;
      rc.we     = 1'b1;
      rc.done   = 1'b1;
      rc.status = ST_OK;
      rc.len    = 8'd1;
      ls_d      = '0;
      lc_d      = '0;
      cs_d      = '0;
      err_d     = ST_OK;
    end else begin
      if (cs_q != CHARS_SAT) begin
        cs_d = cs_q + 9'd1;
      end
      if (ch_i != DOT_CHAR) begin
        if ((10'(cs_d) + 10'd1 > MaxName) || (10'(addr) + 10'd2 > MaxName)) begin
          err_d = ST_NAME_LONG;
        end else if ((err_q == ST_OK) && (10'(lc_q) >= MaxLabel)) begin
          err_d = ST_LABEL_LONG;
        end else if (err_q == ST_OK) begin
          va       = 1'b1;
          ra.we    = 1'b1;
          ra.addr  = addr[7:0];
          ra.wbyte = ch_i;
          lc_d     = lc_q + 7'd1;
        end
      end else if ((err_q == ST_OK) && (lc_q != 7'd0)) begin
        va       = 1'b1;
        ra.we    = 1'b1;
        ra.addr  = ls_q;
        ra.wbyte = {1'b0, lc_q};
        ls_d     = ls_q + 8'(lc_q) + 8'd1;
        lc_d     = '0;
      end
      if (last_i) begin
        if (err_d != ST_OK) begin
          vc        = 1'b1;
          rc.done   = 1'b1;
          rc.status = err_d;
        end else if ((ls_d == 8'd0) && (lc_d == 7'd0)) begin
          vc        = 1'b1;
          rc.done   = 1'b1;
          rc.status = ST_EMPTY;
        end else begin
          ls_end = ls_d;
          if (lc_d != 7'd0) begin
            vb       = 1'b1;
            rb.we    = 1'b1;
            rb.addr  = ls_d;
            rb.wbyte = {1'b0, lc_d};
            ls_end   = ls_d + 8'(lc_d) + 8'd1;
          end
          vc        = 1'b1;
          rc.we     = 1'b1;
          rc.addr   = ls_end;
          rc.done   = 1'b1;
          rc.status = ST_OK;
          rc.len    = ls_end + 8'd1;
        end
        ls_d  = '0;
        lc_d  = '0;
        cs_d  = '0;
        err_d = ST_OK;
      end
    end
  end

  // pack the results in order, dropping absent ones
  always_comb begin
    group_o.slot[0] = va ? ra : (vb ? rb : rc);
    group_o.slot[1] = va ? (vb ? rb : rc) : rc;
    group_o.slot[2] = rc;
    group_o.cnt     = 2'(va) + 2'(vb) + 2'(vc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ls_q  <= '0;
      lc_q  <= '0;
      cs_q  <= '0;
      err_q <= ST_OK;
    end else if (accept_i) begin
      ls_q  <= ls_d;
      lc_q  <= lc_d;
      cs_q  <= cs_d;
      err_q <= err_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dnt_resbuf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dnt_resbuf
// Result register of up to three entries, drained one per transfer.
// ----------------------------------------------------------------------------
module dnt_resbuf (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  wire dnt_pkg::res_group_t group_i,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output dnt_pkg::res_t            out_res_o,
  output logic                     in_ready_o
);
  import dnt_pkg::*;

  res_t [2:0] slot_q;
  logic [1:0] cnt_q;
  logic       xfer;

  assign out_valid_o = (cnt_q != 2'd0);
  assign xfer        = out_valid_o && out_ready_i;
  assign in_ready_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);
  assign out_res_o   = slot_q[0];

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q <= group_i.slot;
    end else if (xfer) begin
      slot_q[0] <= slot_q[1];
      slot_q[1] <= slot_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= group_i.cnt;
    end else if (xfer) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dns_name_text_to_wire.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dns_name_text_to_wire
// Streams a dotted domain name into DNS wire format memory writes.
// ----------------------------------------------------------------------------
// The first result of a character is offered in the cycle after its transfer.
// Throughput: one character per cycle while the output takes results; a final
//   character can give up to three results, so input holds until one is left.
// The three-entry result register drains one result per output transfer.
// Reset clears all label state and the result register count; no clearing pass.
module dns_name_text_to_wire #(
  parameter int MAX_LABEL = 63,
  parameter int MAX_NAME  = 255
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dnt_char_if.sink   char_i,
  dnt_res_if.source  res_o
);
  import dnt_pkg::*;

  res_group_t group;
  res_t       head;
  logic       accept;
  logic       in_ready;

  assign char_i.ready = in_ready;
  assign accept       = char_i.valid && in_ready;

  dnt_parse #(
    .MAX_LABEL (MAX_LABEL),
    .MAX_NAME  (MAX_NAME)
  ) u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .ch_i     (char_i.ch),
    .last_i   (char_i.last),
    .group_o  (group)
  );

  dnt_resbuf u_resbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .group_i     (group),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .out_res_o   (head),
    .in_ready_o  (in_ready)
  );

  assign res_o.write_enable = head.we;
  assign res_o.wire_addr    = head.addr;
  assign res_o.wire_byte    = head.wbyte;
  assign res_o.done_res     = head.done;
  assign res_o.status       = head.status;
  assign res_o.wire_length  = head.len;

endmodule

`default_nettype wire

// File: verif/dnt_wire_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnt_wire_checker
// Watches the character and result channels of the name converter. Each
// accepted character is run through an independent label/length tracker that
// works out the wire writes and the final status it should cause. Each
// accepted result is compared field by field with the oldest expected write.
// ----------------------------------------------------------------------------
module dnt_wire_checker
  import dnt_pkg::*;
#(
  parameter int MAX_LABEL = 63,
  parameter int MAX_NAME  = 255
) (
  input  logic clk_i,
  input  logic rst_ni,
  dnt_char_if  chan_c,
  dnt_res_if   chan_r,
  output int   fail_count_o,
  output int   pending_o
);

  res_t       wire_writes_q[$];
  logic [7:0] open_start = '0;
  logic [6:0] open_len   = '0;
  logic [8:0] char_cnt   = '0;
  logic [8:0] text_len   = '0;
  status_e    first_err  = ST_OK;
  int         mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report(input string what, input int got, input int want);
    mismatches++;
    $display("%0t: result %s got %0d want %0d", $time, what, got, want);
  endtask

  function automatic void expect_write(input logic we, input logic [7:0] waddr,
                                       input logic [7:0] wbyte, input logic done,
                                       input status_e st, input logic [7:0] wlen);
    res_t r;
    r.we     = we;
    r.addr   = waddr;
    r.wbyte  = wbyte;
    r.done   = done;
    r.status = st;
    r.len    = wlen;
    wire_writes_q.push_back(r);
  endfunction

  function automatic void clear_name();
    open_start = '0;
    open_len   = '0;
    char_cnt   = '0;
    text_len   = '0;
    first_err  = ST_OK;
  endfunction

  // write the length byte back at the label start
  function automatic void close_label();
    expect_write(1'b1, open_start, {1'b0, open_len}, 1'b0, ST_OK, 8'd0);
    open_start = open_start + {1'b0, open_len} + 8'd1;
    open_len   = '0;
  endfunction

  function automatic void encode_char(input logic [7:0] c, input logic fin);
    logic [8:0] waddr;
    if (fin && c == DOT_CHAR && char_cnt == '0 && first_err == ST_OK) begin
      expect_write(1'b1, 8'd0, 8'd0, 1'b1, ST_OK, 8'd1);
      clear_name();
    end else begin
      if (char_cnt != CHARS_SAT) char_cnt = char_cnt + 9'd1;
      if (c != DOT_CHAR) begin
        text_len = char_cnt;
        waddr    = {1'b0, open_start} + 9'd1 + {2'b00, open_len};
        if (int'(text_len) + 1 > MAX_NAME || int'(waddr) + 2 > MAX_NAME) begin
          first_err = ST_NAME_LONG;
        end else if (first_err == ST_OK && int'(open_len) >= MAX_LABEL) begin
          first_err = ST_LABEL_LONG;
        end else if (first_err == ST_OK) begin
          expect_write(1'b1, waddr[7:0], c, 1'b0, ST_OK, 8'd0);
          open_len = open_len + 7'd1;
        end
      end else if (first_err == ST_OK && open_len != '0) begin
        close_label();
      end
      if (fin) begin
        if (first_err != ST_OK) begin
          expect_write(1'b0, 8'd0, 8'd0, 1'b1, first_err, 8'd0);
        end else if (open_start == '0 && open_len == '0) begin
          expect_write(1'b0, 8'd0, 8'd0, 1'b1, ST_EMPTY, 8'd0);
        end else begin
          if (open_len != '0) close_label();
          expect_write(1'b1, open_start, 8'd0, 1'b1, ST_OK, open_start + 8'd1);
        end
        clear_name();
      end
    end
  endfunction

  task automatic check_result();
    res_t want;
    if (wire_writes_q.size() == 0) begin
      report("with nothing expected, addr", int'(chan_r.wire_addr), -1);
    end else begin
      want = wire_writes_q.pop_front();
      if (chan_r.write_enable !== want.we)
        report("write_enable", int'(chan_r.write_enable), int'(want.we));
      if (chan_r.wire_addr !== want.addr)
        report("wire_addr", int'(chan_r.wire_addr), int'(want.addr));
      if (chan_r.wire_byte !== want.wbyte)
        report("wire_byte", int'(chan_r.wire_byte), int'(want.wbyte));
      if (chan_r.done_res !== want.done)
        report("done_res", int'(chan_r.done_res), int'(want.done));
      if (chan_r.status !== want.status)
        report("status", int'(chan_r.status), int'(want.status));
      if (chan_r.wire_length !== want.len)
        report("wire_length", int'(chan_r.wire_length), int'(want.len));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_name();
      wire_writes_q.delete();
      pending_o <= 0;
    end else begin
      if (chan_c.valid && chan_c.ready) encode_char(chan_c.ch, chan_c.last);
      if (chan_r.valid && chan_r.ready) check_result();
      pending_o <= wire_writes_q.size();
    end
  end

endmodule

// File: verif/tb_dns_name_text_to_wire.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dns_name_text_to_wire
// Feeds dotted names to the converter: a few hand-picked names first, then
// random names, mostly well formed with random bytes, plus noise, dot-only
// names, over-long labels and a name that runs past the wire limit. Both
// channels idle at random; the result side once holds off long enough to fill
// the block. A separate checker predicts and compares every result; this
// module gives the verdict.
// ----------------------------------------------------------------------------
module tb_dns_name_text_to_wire;
  import dnt_pkg::*;

  localparam int LABEL_MAX      = 63;
  localparam int NAME_MAX       = 255;
  localparam int RANDOM_ITEMS   = 410;
  localparam int HOLD_CYCLES    = 200;
  localparam int SETTLE_CYCLES  = 6;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef logic [7:0] name_q_t[$];

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  bit   stall_req  = 1'b0;
  bit   name_quiet = 1'b0;

  dnt_char_if chr ();
  dnt_res_if  res ();

  dns_name_text_to_wire #(
    .MAX_LABEL (LABEL_MAX),
    .MAX_NAME  (NAME_MAX)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (chr),
    .res_o  (res)
  );

  dnt_wire_checker #(
    .MAX_LABEL (LABEL_MAX),
    .MAX_NAME  (NAME_MAX)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .chan_c       (chr),
    .chan_r       (res),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic [7:0] label_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == DOT_CHAR);
    return c;
  endfunction

  function automatic void add_label(ref name_q_t q, input int n);
    for (int i = 0; i < n; i++) q.push_back(label_char());
  endfunction

  task automatic send_char(input logic [7:0] c, input logic fin);
    int gap;
    gap = name_quiet ? 0 : gap_len();
    if (gap > 0) begin
      chr.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    chr.valid <= 1'b1;
    chr.ch    <= c;
    chr.last  <= fin;
    @(posedge clk_i);
    while (!chr.ready) @(posedge clk_i);
  endtask

  task automatic send_name(input name_q_t q);
    foreach (q[i]) send_char(q[i], i == q.size() - 1);
  endtask

  task automatic drain();
    chr.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // result side: random stalls, quiet stretches, one long hold-off on request
  initial begin
    int busy;
    int quiet_left;
    busy       = 0;
    quiet_left = 0;
    res.ready  = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (stall_req) begin
        stall_req = 1'b0;
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        if (quiet_left > 0) quiet_left--;
        else if ($urandom_range(0, 199) == 0) quiet_left = $urandom_range(20, 80);
        if (busy > 0) begin
          busy--;
          res.ready <= 1'b0;
        end else if (quiet_left == 0 && $urandom_range(0, 3) == 0) begin
          busy = gap_len();
          res.ready <= (busy == 0);
          if (busy > 0) busy--;
        end else begin
          res.ready <= 1'b1;
        end
        @(posedge clk_i);
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((chr.valid && chr.ready) || (res.valid && res.ready)) idle = 0;
      else idle++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    name_q_t q;
    int      sent;
    int      nidx;
    int      kind;
    int      nlab;

    chr.valid = 1'b0;
    chr.ch    = '0;
    chr.last  = 1'b0;
    rst_ni    = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // hand-picked names: root, dots only, byte extremes, empty labels
    send_name('{DOT_CHAR});
    send_name('{DOT_CHAR, DOT_CHAR});
    send_name('{8'hFF});
    send_name('{8'h01});
    send_name('{8'h41, DOT_CHAR});
    send_name('{DOT_CHAR, 8'h7F});
    send_name('{8'h80, DOT_CHAR, DOT_CHAR, 8'hFE});
    send_name('{8'h2D, DOT_CHAR, 8'h2F, DOT_CHAR});
    send_name('{DOT_CHAR, DOT_CHAR, DOT_CHAR});
    send_name('{8'h61, 8'h62, DOT_CHAR, 8'h55, 8'hAA});
    drain();

    sent = 0;
    nidx = 0;
    while (sent < RANDOM_ITEMS) begin
      q.delete();
      name_quiet = ($urandom_range(0, 4) == 0);
      if (nidx == 6) begin
        for (int i = 0; i < 3; i++) begin
          add_label(q, 63);
          q.push_back(DOT_CHAR);
        end
        add_label(q, 62);
      end else begin
        kind = $urandom_range(0, 99);
        if (nidx == 3) begin
          stall_req  = 1'b1;
          name_quiet = 1'b1;
          add_label(q, 8);
          q.push_back(DOT_CHAR);
          add_label(q, 12);
        end else if (kind < 68) begin
          if ($urandom_range(0, 19) == 0) q.push_back(DOT_CHAR);
          nlab = $urandom_range(1, 4);
          for (int i = 0; i < nlab; i++) begin
            if (i > 0) q.push_back(DOT_CHAR);
            if (i > 0 && $urandom_range(0, 9) == 0) q.push_back(DOT_CHAR);
            add_label(q, $urandom_range(1, 8));
          end
          if ($urandom_range(0, 4) == 0) q.push_back(DOT_CHAR);
        end else if (kind < 83) begin
          nlab = $urandom_range(1, 10);
          for (int i = 0; i < nlab; i++) begin
            if ($urandom_range(0, 99) < 35) q.push_back(DOT_CHAR);
            else q.push_back(label_char());
          end
        end else if (kind < 89) begin
          nlab = $urandom_range(1, 4);
          for (int i = 0; i < nlab; i++) q.push_back(DOT_CHAR);
        end else begin
          add_label(q, $urandom_range(60, 66));
          if ($urandom_range(0, 1) == 0) begin
            q.push_back(DOT_CHAR);
            add_label(q, $urandom_range(1, 5));
          end
        end
      end
      send_name(q);
      sent += q.size();
      if (nidx == 10 || $urandom_range(0, 49) == 0) drain();
      nidx++;
    end

    drain();
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/dnt_pkg.sv
hw/rtl/dnt_if.sv
hw/rtl/dnt_parse.sv
hw/rtl/dnt_resbuf.sv
hw/rtl/dns_name_text_to_wire.sv
verif/dnt_wire_checker.sv
verif/tb_dns_name_text_to_wire.sv
